// File: design/lzbd_pkg.sv
package lzbd_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned HISTORY_DEPTH_DEF = 65536;
  localparam int unsigned MIN_MATCH_LEN_DEF = 4;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [3:0] NIBBLE_EXT = 4'd15;
  localparam logic [7:0] BYTE_EXT   = 8'd255;

  // Configuration register indexes.
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_EXP_LEN  = 1'b0;
  localparam cfg_idx_t CFG_EXP_HASH = 1'b1;

  // Frame status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TRUNC    = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_BAD_OFF  = 3'd3;
  localparam logic [2:0] ST_LEN      = 3'd4;
  localparam logic [2:0] ST_HASH     = 3'd5;

  typedef enum logic [7:0] {
    PH_TOKEN    = 8'b0000_0001,
    PH_LITEXT   = 8'b0000_0010,
    PH_LITERAL  = 8'b0000_0100,
    PH_OFF_LO   = 8'b0000_1000,
    PH_OFF_HI   = 8'b0001_0000,
    PH_MATCHEXT = 8'b0010_0000,
    PH_COPY     = 8'b0100_0000,
    PH_IDLE     = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic       frame_start;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        byte_taken;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] running_hash;
  } out_t;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {25'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// File: design/lz4_style_block_decoder_unit.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    lzbd_pkg::in_t
// out      output     out_valid_o / out_ready_i  lzbd_pkg::out_t
// cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// Every input beat gives one output beat; the sustained rate is one beat per cycle while out_ready_i is high.
// A result passes the read stage, with the registered read of the history memory
// (one write port, one read port), and then the output register.
// Reset clears the control state only; the history memory is not cleared and needs no pass.
// When the output stalls, the output register and then the read stage fill before
// in_ready_o drops, so one new beat is still taken while a result waits.
module lz4_style_block_decoder_unit #(
  parameter int unsigned HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned MIN_MATCH_LEN = lzbd_pkg::MIN_MATCH_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lzbd_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lzbd_pkg::out_t     out_data_o,
  input  logic               cfg_we_i,
  input  lzbd_pkg::cfg_idx_t cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);
  import lzbd_pkg::*;

  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [16:0] DEPTH17 = 17'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [31:0] MIN32 = 32'(MIN_MATCH_LEN);

  // One decoded beat waiting for its history byte.
  typedef struct packed {
    logic          taken;
    logic          emit;
    logic          is_copy;
    logic [7:0]    lit;
    logic          fwd;
    logic [7:0]    fwd_byte;
    logic [AW-1:0] wr_addr;
    logic          fs;
    logic          fail;
    logic          finish;
    logic          len_ok;
    logic [2:0]    code;
  } pend_t;

  function automatic logic too_long(logic [31:0] pc, logic [31:0] len, logic [31:0] cap);
    logic [32:0] s;
    s = {1'b0, pc} + {1'b0, len};
    return s > {1'b0, cap};
  endfunction

  logic [31:0] exp_len_q, exp_hash_q;

  phase_e        phase_q, phase_d;
  logic [3:0]    mnib_q, mnib_d;
  logic [31:0]   lit_left_q, lit_left_d;
  logic [31:0]   match_left_q, match_left_d;
  logic [15:0]   dist_q, dist_d;
  logic [31:0]   prod_q, prod_d;
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic          end_after_q, end_after_d;

  logic          p_valid_q, b_valid_q;
  pend_t         p_q, a_pend;
  out_t          b_q;
  logic [7:0]    rdata_q;
  logic [31:0]   hash_q;
  logic [2:0]    err_q;

  logic          p_move, in_acc;
  logic [AW-1:0] src;
  logic [7:0]    p_byte;
  logic [31:0]   hash_base, hash_new;
  logic [2:0]    err_new;

  assign p_move     = p_valid_q && (!b_valid_q || out_ready_i);
  assign in_ready_o = !p_valid_q || p_move;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q  <= '0;
      exp_hash_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EXP_LEN:  exp_len_q  <= cfg_data_i;
        CFG_EXP_HASH: exp_hash_q <= cfg_data_i;
      endcase
    end
  end

  // Decode of the accepted beat: all sequence state is settled here, only the
  // copied byte itself waits for the memory.
  always_comb begin
    phase_e        ph;
    logic [7:0]    b;
    logic          last;
    logic          lit_rdy, match_rdy, fin;
    logic [16:0]   diff;
    logic [15:0]   md;

    b    = in_data_i.data_byte;
    last = in_data_i.last_byte;

    ph           = in_data_i.frame_start ? PH_TOKEN : phase_q;
    mnib_d       = in_data_i.frame_start ? 4'd0 : mnib_q;
    lit_left_d   = in_data_i.frame_start ? 32'd0 : lit_left_q;
    match_left_d = in_data_i.frame_start ? 32'd0 : match_left_q;
    dist_d       = in_data_i.frame_start ? 16'd0 : dist_q;
    prod_d       = in_data_i.frame_start ? 32'd0 : prod_q;
    wr_ptr_d     = in_data_i.frame_start ? '0 : wr_ptr_q;
    end_after_d  = in_data_i.frame_start ? 1'b0 : end_after_q;
    phase_d      = ph;

    a_pend         = '0;
    a_pend.fs      = in_data_i.frame_start;
    a_pend.wr_addr = wr_ptr_d;
    lit_rdy   = 1'b0;
    match_rdy = 1'b0;
    fin       = 1'b0;
    md        = '0;

    // Copy source, wrapped into the history ring.
    diff = 17'(wr_ptr_d) - {1'b0, dist_d};
    if (diff[16]) diff = diff + DEPTH17;
    src = diff[AW-1:0];

    if (ph == PH_COPY) begin
      a_pend.emit    = 1'b1;
      a_pend.is_copy = 1'b1;
      match_left_d   = match_left_d - 32'd1;
      if (match_left_d == 32'd0) begin
        if (end_after_d) fin = 1'b1;
        else phase_d = PH_TOKEN;
      end
    end else if (ph != PH_IDLE && in_data_i.byte_valid) begin
      a_pend.taken = 1'b1;
      unique case (ph)
        PH_TOKEN: begin
          mnib_d     = b[3:0];
          lit_left_d = {28'b0, b[7:4]};
          if (b[7:4] == NIBBLE_EXT) begin
            if (last) begin
              a_pend.fail = 1'b1;
              a_pend.code = ST_TRUNC;
            end else phase_d = PH_LITEXT;
          end else lit_rdy = 1'b1;
        end
        PH_LITEXT: begin
          lit_left_d = sat_add(lit_left_d, b);
          if (b == BYTE_EXT) begin
            if (last) begin
              a_pend.fail = 1'b1;
              a_pend.code = ST_TRUNC;
            end
          end else lit_rdy = 1'b1;
        end
        PH_LITERAL: begin
          a_pend.emit = 1'b1;
          a_pend.lit  = b;
          lit_left_d  = lit_left_d - 32'd1;
          if (lit_left_d == 32'd0) begin
            if (last) fin = 1'b1;
            else phase_d = PH_OFF_LO;
          end else if (last) begin
            a_pend.fail = 1'b1;
            a_pend.code = ST_TRUNC;
          end
        end
        PH_OFF_LO: begin
          dist_d = {8'b0, b};
          if (last) begin
            a_pend.fail = 1'b1;
            a_pend.code = ST_TRUNC;
          end else phase_d = PH_OFF_HI;
        end
        PH_OFF_HI: begin
          md     = {b, dist_d[7:0]};
          dist_d = md;
          if (md == 16'd0 || {16'b0, md} > prod_d || {1'b0, md} > DEPTH17) begin
            a_pend.fail = 1'b1;
            a_pend.code = ST_BAD_OFF;
          end else begin
            match_left_d = {28'b0, mnib_d} + MIN32;
            if (mnib_d == NIBBLE_EXT) begin
              if (last) begin
                a_pend.fail = 1'b1;
                a_pend.code = ST_TRUNC;
              end else phase_d = PH_MATCHEXT;
            end else match_rdy = 1'b1;
          end
        end
        PH_MATCHEXT: begin
          match_left_d = sat_add(match_left_d, b);
          if (b == BYTE_EXT) begin
            if (last) begin
              a_pend.fail = 1'b1;
              a_pend.code = ST_TRUNC;
            end
          end else match_rdy = 1'b1;
        end
        default: ;
      endcase
    end

    if (lit_rdy) begin
      if (last && lit_left_d != 32'd0) begin
        a_pend.fail = 1'b1;
        a_pend.code = ST_TRUNC;
      end else if (too_long(prod_d, lit_left_d, exp_len_q)) begin
        a_pend.fail = 1'b1;
        a_pend.code = ST_OVERFLOW;
      end else if (lit_left_d == 32'd0) begin
        if (last) fin = 1'b1;
        else phase_d = PH_OFF_LO;
      end else phase_d = PH_LITERAL;
    end

    if (match_rdy) begin
      if (too_long(prod_d, match_left_d, exp_len_q)) begin
        a_pend.fail = 1'b1;
        a_pend.code = ST_OVERFLOW;
      end else begin
        end_after_d = last;
        phase_d     = PH_COPY;
      end
    end

    if (a_pend.emit) begin
      prod_d   = prod_d + 32'd1;
      wr_ptr_d = (wr_ptr_d == LAST_ADDR) ? '0 : wr_ptr_d + AW'(1);
    end

    if (a_pend.fail || fin) phase_d = PH_IDLE;
    a_pend.finish = fin;
    a_pend.len_ok = (prod_d == exp_len_q);

    // The beat ahead writes its byte on the same edge as this read.
    a_pend.fwd      = a_pend.is_copy && p_valid_q && p_q.emit && (p_q.wr_addr == src);
    a_pend.fwd_byte = p_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TOKEN;
      mnib_q       <= '0;
      lit_left_q   <= '0;
      match_left_q <= '0;
      dist_q       <= '0;
      prod_q       <= '0;
      wr_ptr_q     <= '0;
      end_after_q  <= 1'b0;
    end else if (in_acc) begin
      phase_q      <= phase_d;
      mnib_q       <= mnib_d;
      lit_left_q   <= lit_left_d;
      match_left_q <= match_left_d;
      dist_q       <= dist_d;
      prod_q       <= prod_d;
      wr_ptr_q     <= wr_ptr_d;
      end_after_q  <= end_after_d;
    end
  end

  logic [7:0] hist_mem [HISTORY_DEPTH];

  always_ff @(posedge clk_i) begin
    if (p_move && p_q.emit) hist_mem[p_q.wr_addr] <= p_byte;
    if (in_acc && a_pend.is_copy) rdata_q <= hist_mem[src];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (in_acc) begin
      p_valid_q <= 1'b1;
    end else if (p_move) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) p_q <= a_pend;
  end

  always_comb begin
    if (!p_q.emit) p_byte = 8'd0;
    else if (!p_q.is_copy) p_byte = p_q.lit;
    else if (p_q.fwd) p_byte = p_q.fwd_byte;
    else p_byte = rdata_q;
  end

  assign hash_base = p_q.fs ? FNV_BASIS : hash_q;
  assign hash_new  = p_q.emit ? (hash_base ^ {24'b0, p_byte}) * FNV_PRIME : hash_base;

  always_comb begin
    err_new = p_q.fs ? ST_OK : err_q;
    if (p_q.fail) err_new = p_q.code;
    else if (p_q.finish) begin
      if (!p_q.len_ok) err_new = ST_LEN;
      else if (hash_new != exp_hash_q) err_new = ST_HASH;
      else err_new = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q    <= FNV_BASIS;
      err_q     <= ST_OK;
      b_valid_q <= 1'b0;
    end else begin
      if (p_move) begin
        hash_q    <= hash_new;
        err_q     <= err_new;
        b_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_move) begin
      b_q.byte_taken   <= p_q.taken;
      b_q.out_valid    <= p_q.emit;
      b_q.out_byte     <= p_byte;
      b_q.done_res     <= p_q.fail || p_q.finish;
      b_q.status       <= err_new;
      b_q.running_hash <= hash_new;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_data_o  = b_q;

`ifndef SYNTHESIS
  a_copy_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && p_q.is_copy |-> p_q.emit && !p_q.taken)
    else $error("copy beat must emit and must not take a byte");

  a_wr_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, wr_ptr_q} < (AW + 1)'(HISTORY_DEPTH))
    else $error("history write pointer out of range");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && (p_q.fail || p_q.finish) |-> phase_q == PH_IDLE)
    else $error("frame ended but decoder is not idle");

  a_ok_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_q.done_res && b_q.status == ST_OK |-> b_q.running_hash == exp_hash_q)
    else $error("frame reported ok with a hash mismatch");
`endif

endmodule

// File: sim/lzbd_stream_monitor.sv
module lzbd_stream_monitor
  import lzbd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned MIN_MATCH_LEN = MIN_MATCH_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  input  logic        cfg_we_i,
  input  cfg_idx_t    cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int unsigned errors_o,
  output int unsigned outstanding_o,
  output int unsigned checked_o
);

  logic [31:0] want_len;
  logic [31:0] want_hash;

  // Decoder state as this monitor tracks it.
  phase_e      phase_q;
  logic [3:0]  match_nib;
  logic [31:0] lit_left;
  logic [31:0] copy_left;
  logic [15:0] back_dist;
  logic [31:0] produced;
  logic [31:0] fnv;
  logic [2:0]  status_q;
  logic        end_on_copy;
  logic [7:0]  window [HISTORY_DEPTH];

  out_t beat_res;
  out_t result_q [$];

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {25'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void clear_frame_state();
    phase_q     = PH_TOKEN;
    match_nib   = '0;
    lit_left    = '0;
    copy_left   = '0;
    back_dist   = '0;
    produced    = '0;
    fnv         = FNV_BASIS;
    status_q    = ST_OK;
    end_on_copy = 1'b0;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    window[produced % HISTORY_DEPTH] = b;
    produced = produced + 32'd1;
    fnv = (fnv ^ {24'd0, b}) * FNV_PRIME;
    beat_res.out_valid = 1'b1;
    beat_res.out_byte  = b;
  endfunction

  function automatic void stop(logic [2:0] code);
    status_q = code;
    phase_q  = PH_IDLE;
    beat_res.done_res = 1'b1;
  endfunction

  function automatic void conclude();
    if (produced != want_len) stop(ST_LEN);
    else if (fnv != want_hash) stop(ST_HASH);
    else stop(ST_OK);
  endfunction

  function automatic logic overruns(logic [31:0] n);
    return ({1'b0, produced} + {1'b0, n}) > {1'b0, want_len};
  endfunction

  function automatic void literals_known(logic last);
    if (last && lit_left != 0) stop(ST_TRUNC);
    else if (overruns(lit_left)) stop(ST_OVERFLOW);
    else if (lit_left == 0) begin
      if (last) conclude();
      else phase_q = PH_OFF_LO;
    end else phase_q = PH_LITERAL;
  endfunction

  function automatic void match_known(logic last);
    if (overruns(copy_left)) stop(ST_OVERFLOW);
    else begin
      end_on_copy = last;
      phase_q = PH_COPY;
    end
  endfunction

  // Advances the tracked decoder by one input beat and returns the beat it must answer with.
  function automatic out_t decode_beat(in_t x);
    logic [31:0] src;
    beat_res = '0;
    if (x.frame_start) clear_frame_state();
    if (phase_q == PH_COPY) begin
      src = (produced - {16'd0, back_dist}) % HISTORY_DEPTH;
      emit_byte(window[src]);
      copy_left = copy_left - 32'd1;
      if (copy_left == 0) begin
        if (end_on_copy) conclude();
        else phase_q = PH_TOKEN;
      end
    end else if (phase_q != PH_IDLE && x.byte_valid) begin
      beat_res.byte_taken = 1'b1;
      case (phase_q)
        PH_TOKEN: begin
          match_nib = x.data_byte[3:0];
          lit_left  = {28'd0, x.data_byte[7:4]};
          if (x.data_byte[7:4] == NIBBLE_EXT) begin
            if (x.last_byte) stop(ST_TRUNC);
            else phase_q = PH_LITEXT;
          end else literals_known(x.last_byte);
        end
        PH_LITEXT: begin
          lit_left = add_sat(lit_left, x.data_byte);
          if (x.data_byte == BYTE_EXT) begin
            if (x.last_byte) stop(ST_TRUNC);
          end else literals_known(x.last_byte);
        end
        PH_LITERAL: begin
          emit_byte(x.data_byte);
          lit_left = lit_left - 32'd1;
          if (lit_left == 0) begin
            if (x.last_byte) conclude();
            else phase_q = PH_OFF_LO;
          end else if (x.last_byte) stop(ST_TRUNC);
        end
        PH_OFF_LO: begin
          back_dist = {8'd0, x.data_byte};
          if (x.last_byte) stop(ST_TRUNC);
          else phase_q = PH_OFF_HI;
        end
        PH_OFF_HI: begin
          back_dist[15:8] = x.data_byte;
          if (back_dist == 0 || {16'd0, back_dist} > produced ||
              {16'd0, back_dist} > HISTORY_DEPTH) begin
            stop(ST_BAD_OFF);
          end else begin
            copy_left = {28'd0, match_nib} + MIN_MATCH_LEN;
            if (match_nib == NIBBLE_EXT) begin
              if (x.last_byte) stop(ST_TRUNC);
              else phase_q = PH_MATCHEXT;
            end else match_known(x.last_byte);
          end
        end
        default: begin
          copy_left = add_sat(copy_left, x.data_byte);
          if (x.data_byte == BYTE_EXT) begin
            if (x.last_byte) stop(ST_TRUNC);
          end else match_known(x.last_byte);
        end
      endcase
    end
    beat_res.status       = status_q;
    beat_res.running_hash = fnv;
    return beat_res;
  endfunction

  task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      want_len  = '0;
      want_hash = '0;
      clear_frame_state();
      result_q.delete();
      errors_o  = 0;
      checked_o = 0;
      outstanding_o <= 0;
    end else begin
      // Retire before accepting, so a result never meets the beat taken at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("output beat with no result pending");
          errors_o++;
        end else begin
          want = result_q.pop_front();
          flag_field("byte_taken", 32'(want.byte_taken), 32'(out_data_i.byte_taken));
          flag_field("out_valid", 32'(want.out_valid), 32'(out_data_i.out_valid));
          flag_field("out_byte", 32'(want.out_byte), 32'(out_data_i.out_byte));
          flag_field("done_res", 32'(want.done_res), 32'(out_data_i.done_res));
          flag_field("status", 32'(want.status), 32'(out_data_i.status));
          flag_field("running_hash", want.running_hash, out_data_i.running_hash);
          checked_o++;
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_EXP_LEN) want_len = cfg_data_i;
        else want_hash = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) result_q.push_back(decode_beat(in_data_i));
      outstanding_o <= result_q.size();
    end
  end

endmodule

// File: sim/tb_lz4_style_block_decoder_unit.sv
module tb_lz4_style_block_decoder_unit;
  import lzbd_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1100;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MATCH_FLOOR   = MIN_MATCH_LEN_DEF;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  cfg_idx_t    cfg_idx;
  logic [31:0] cfg_data;

  int unsigned fail_count;
  int unsigned results_pending;
  int unsigned results_checked;
  int unsigned beats_sent;
  int unsigned frames_sent;
  int unsigned frames_damaged;
  int unsigned cycles = 0;

  // Frame under construction: the input beats and the bytes they should decode to.
  in_t         beat_q [$];
  logic [7:0]  plain_q [$];
  bit          start_flag;
  bit          gaps_in_frame;

  always #6 clk_i = ~clk_i;

  lz4_style_block_decoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  lzbd_stream_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .errors_o      (fail_count),
    .outstanding_o (results_pending),
    .checked_o     (results_checked)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL lz4_style_block_decoder_unit");
      $finish;
    end
  end

  // A window of the run where neither side idles.
  function automatic bit calm();
    return beats_sent >= 600 && beats_sent < 800;
  endfunction

  // Receiver: random stalls, plus one long hold-off that backs the block up into its input.
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held && beats_sent >= 350) begin
        held      = 1'b1;
        hold_left = 120;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm() || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  function automatic void open_frame();
    beat_q.delete();
    plain_q.delete();
    start_flag = 1'b1;
  endfunction

  function automatic void push_beat(bit has_byte, logic [7:0] b, bit last);
    in_t x;
    x.frame_start = start_flag;
    x.byte_valid  = has_byte;
    x.data_byte   = b;
    x.last_byte   = last;
    start_flag = 1'b0;
    beat_q.push_back(x);
  endfunction

  // Outside a match copy an empty beat does nothing, so they may be sprinkled in freely.
  function automatic void push_byte(logic [7:0] b, bit last);
    if (gaps_in_frame && $urandom_range(0, 7) == 0) push_beat(1'b0, 8'($urandom), 1'($urandom));
    push_beat(1'b1, b, last);
  endfunction

  function automatic void push_extension(int unsigned rest, bit last);
    while (rest >= 255) begin
      push_byte(BYTE_EXT, 1'b0);
      rest -= 255;
    end
    push_byte(8'(rest), last);
  endfunction

  function automatic void add_sequence(int unsigned lits, bit with_match, int unsigned mlen,
                                       int unsigned offset, bit closing);
    logic [3:0]  lit_nib;
    logic [3:0]  m_nib;
    logic [7:0]  b;
    int unsigned extra;
    int unsigned base;
    int unsigned i;
    lit_nib = (lits >= 15) ? NIBBLE_EXT : 4'(lits);
    extra   = with_match ? mlen - MATCH_FLOOR : $urandom_range(0, 15);
    m_nib   = (extra >= 15) ? NIBBLE_EXT : 4'(extra);
    push_byte({lit_nib, m_nib}, closing && !with_match && lits == 0);
    if (lits >= 15) push_extension(lits - 15, 1'b0);
    for (i = 0; i < lits; i++) begin
      b = 8'($urandom);
      plain_q.push_back(b);
      push_byte(b, closing && !with_match && i == lits - 1);
    end
    if (with_match) begin
      push_byte(8'(offset), 1'b0);
      push_byte(8'(offset >> 8), closing && extra < 15);
      if (extra >= 15) push_extension(extra - 15, closing);
      base = plain_q.size();
      // Copy beats: whatever they carry is ignored while the block copies.
      for (i = 0; i < mlen; i++) begin
        if (offset != 0 && offset <= base) plain_q.push_back(plain_q[plain_q.size() - offset]);
        push_beat(1'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endfunction

  function automatic logic [31:0] plain_hash();
    logic [31:0] h;
    h = FNV_BASIS;
    foreach (plain_q[i]) h = (h ^ {24'd0, plain_q[i]}) * FNV_PRIME;
    return h;
  endfunction

  task automatic send_beat(input in_t b);
    while (!calm() && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [31:0] length, input logic [31:0] hash);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_EXP_LEN;
    cfg_data <= length;
    @(posedge clk_i);
    cfg_idx  <= CFG_EXP_HASH;
    cfg_data <= hash;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic play_frame(input logic [31:0] length, input logic [31:0] hash);
    wait_idle();
    load_config(length, hash);
    foreach (beat_q[i]) send_beat(beat_q[i]);
    frames_sent++;
  endtask

  task automatic random_frame();
    int unsigned kind;
    int unsigned nseq;
    int unsigned s;
    int unsigned lits;
    int unsigned mlen;
    int unsigned offset;
    int unsigned avail;
    int unsigned pick;
    bit          with_match;
    logic [31:0] length;
    logic [31:0] hash;
    kind = $urandom_range(0, 99);
    gaps_in_frame = $urandom_range(0, 2) != 0;
    open_frame();
    nseq = $urandom_range(1, 4);
    for (s = 0; s < nseq; s++) begin
      lits = ($urandom_range(0, 79) == 0) ? $urandom_range(270, 300) : $urandom_range(0, 12);
      with_match = (s + 1 < nseq) || $urandom_range(0, 1);
      if (kind >= 83 && kind < 90 && s == 0) with_match = 1'b1;
      if (with_match && plain_q.size() + lits == 0) lits = 1;
      mlen = ($urandom_range(0, 79) == 0) ? $urandom_range(275, 290)
                                          : $urandom_range(MATCH_FLOOR, 18);
      avail = plain_q.size() + lits;
      if (kind >= 83 && kind < 90 && s == 0)
        offset = $urandom_range(0, 1) ? 0 : avail + $urandom_range(1, 300);
      else if ($urandom_range(0, 1))
        offset = $urandom_range(1, (avail < 8) ? avail : 8);
      else
        offset = $urandom_range(1, (avail > 65535) ? 65535 : avail);
      add_sequence(lits, with_match, mlen, offset, s + 1 == nseq);
    end
    length = plain_q.size();
    hash   = plain_hash();
    if (kind < 55) begin
    end else if (kind < 62) begin
      hash ^= 32'd1 << $urandom_range(0, 31);
    end else if (kind < 69) begin
      length = $urandom_range(0, 1) ? length + 32'd1 : 32'hFFFF_FFFF;
    end else if (kind < 76) begin
      if (length != 0) length = $urandom_range(0, length - 1);
    end else if (kind < 83) begin
      pick = $urandom_range(0, beat_q.size() - 1);
      beat_q[pick].last_byte = 1'b1;
    end else if (kind >= 90 && beat_q.size() > 1) begin
      // A new frame opens in the middle of this one.
      pick = $urandom_range(1, beat_q.size() - 1);
      beat_q[pick].frame_start = 1'b1;
    end
    // Bytes after the end of a frame must be left alone.
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(2, 4)) push_beat(1'($urandom), 8'($urandom), 1'($urandom));
    if (kind >= 55) frames_damaged++;
    play_frame(length, hash);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_EXP_LEN;
    cfg_data       = '0;
    beats_sent     = 0;
    frames_sent    = 0;
    frames_damaged = 0;
    gaps_in_frame  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // An empty frame: wrong hash with all-zero registers, then accepted.
    open_frame();
    add_sequence(0, 1'b0, 0, 0, 1'b1);
    play_frame('0, '0);
    play_frame('0, FNV_BASIS);

    // One literal: length mismatch against all-ones registers, then overflow at zero length.
    open_frame();
    add_sequence(1, 1'b0, 0, 0, 1'b1);
    play_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    play_frame('0, plain_hash());

    // Stream ends while a literal is still owed.
    open_frame();
    add_sequence(2, 1'b0, 0, 0, 1'b1);
    beat_q[1].last_byte = 1'b1;
    play_frame(2, plain_hash());

    // Zero distance, then a distance past the bytes produced.
    open_frame();
    add_sequence(1, 1'b1, MATCH_FLOOR, 0, 1'b1);
    play_frame(32'd5, plain_hash());
    open_frame();
    add_sequence(1, 1'b1, MATCH_FLOOR, 2, 1'b1);
    play_frame(32'd5, plain_hash());

    // Overlapping copy of a single byte, ending on the match.
    open_frame();
    add_sequence(1, 1'b1, MATCH_FLOOR, 1, 1'b1);
    play_frame(plain_q.size(), plain_hash());

    while (beats_sent < ITEM_TARGET) random_frame();
    wait_idle();

    $display("Covered %0d frames (%0d damaged or with mismatched registers), %0d input beats,",
             frames_sent, frames_damaged, beats_sent);
    $display("%0d result beats compared.", results_checked);
    if (fail_count == 0) begin
      $display("PASS lz4_style_block_decoder_unit");
    end else begin
      $display("FAIL lz4_style_block_decoder_unit");
    end
    $finish;
  end

endmodule
